// ===== rtl/ehf_pkg.sv =====
package ehf_pkg;

	localparam int LOG_TABLE_ENTRIES_DEF = 256;
	localparam int DIRECTIONS = 15;
	localparam int FIRST_DIAG = 7;
	localparam int QUEUE_DEPTH = 4;

	localparam int F_W = 32;
	localparam int SUM_W = 48;
	localparam int TERM_W = 50;
	localparam int ACC_W = 52;
	localparam int FA_W = 43;
	localparam int X_W = 42;
	localparam int L_W = 40;
	localparam int OP_W = 48;
	localparam int P_W = 96;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// log2 of the inverse weight divided by 9, plus 3 (w = 9 * 2^(k-3))
	localparam logic [2:0] K_CENTER = 3'd2;
	localparam logic [2:0] K_AXIS = 3'd3;
	localparam logic [2:0] K_DIAG = 3'd6;

	typedef struct packed {
		logic signed [F_W-1:0] f;
		logic signed [F_W:0] diff;
		logic [F_W-1:0] mag_alpha;
		logic [F_W:0] mag_diff;
		logic pm_neg;
		logic [2:0] k;
		logic last;
	} ehf_item_t;

	// shift-subtract quotient; elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] r;
		int b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// ln(1 + i/n) in Q.32 through 2*atanh(i/(2n+i)); elaboration only
	function automatic logic [31:0] ln_entry(input int i, input int n);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] acc;
		logic [63:0] nn;
		int t;
		z = udiv64(64'(i) << 32, 64'(2 * n + i));
		z2 = (z * z) >> 32;
		p = z;
		acc = '0;
		nn = 64'd1;
		for (t = 0; t < 64; t++) begin
			if (p != '0) begin
				acc = acc + udiv64(p, nn);
				p = (p * z2) >> 32;
				nn = nn + 64'd2;
			end
		end
		return 32'(acc * 64'd2);
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi_lim;
		logic signed [ACC_W-1:0] lo_lim;
		hi_lim = ACC_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
		lo_lim = -ACC_W'(64'sd1 <<< (SUM_W - 1));
		if (v > hi_lim) begin
			return hi_lim[SUM_W-1:0];
		end else if (v < lo_lim) begin
			return lo_lim[SUM_W-1:0];
		end
		return v[SUM_W-1:0];
	endfunction

endpackage

// ===== rtl/ehf_front.sv =====
module ehf_front import ehf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [F_W-1:0] f_value,
	input  logic signed [F_W-1:0] feq_value,
	input  logic signed [F_W-1:0] alpha,
	input  logic [3:0] direction,
	input  logic last,
	output logic push,
	output ehf_item_t push_item,
	input  logic q_full
);

	logic valid_s1;
	ehf_item_t item_s1;
	ehf_item_t cls;
	logic accept;

	// direction 15 is not clamped; like 14 it falls in the diagonal class
	always_comb begin
		cls.f = f_value;
		cls.diff = $signed({feq_value[F_W-1], feq_value}) - $signed({f_value[F_W-1], f_value});
		cls.mag_alpha = alpha[F_W-1] ? F_W'(-alpha) : F_W'(alpha);
		cls.mag_diff = cls.diff[F_W] ? (F_W+1)'(-cls.diff) : (F_W+1)'(cls.diff);
		cls.pm_neg = alpha[F_W-1] != cls.diff[F_W];
		if (direction == 4'd0) begin
			cls.k = K_CENTER;
		end else if (direction < 4'(FIRST_DIAG)) begin
			cls.k = K_AXIS;
		end else begin
			cls.k = K_DIAG;
		end
		cls.last = last;
	end

	assign in_stall = valid_s1 && q_full;
	assign accept = in_valid && !in_stall;
	assign push = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== rtl/ehf_queue.sv =====
module ehf_queue import ehf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ehf_item_t push_item,
	output logic full,
	input  logic pop,
	output logic rd_valid,
	output ehf_item_t rd_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ehf_item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/ehf_back.sv =====
module ehf_back import ehf_pkg::*; #(
	parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_valid,
	input  ehf_item_t rd_item,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [SUM_W-1:0] entropy_sum,
	output logic signed [SUM_W-1:0] entropy_change,
	output logic signed [SUM_W-1:0] entropy_slope,
	output logic zero_hit
);

	localparam int IW = $clog2(LOG_TABLE_ENTRIES + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL = 4'd1;
	localparam logic [3:0] ST_RND = 4'd2;
	localparam logic [3:0] ST_LN1 = 4'd3;
	localparam logic [3:0] ST_LN2 = 4'd4;
	localparam logic [3:0] ST_LN3 = 4'd5;
	localparam logic [3:0] ST_LN4 = 4'd6;
	localparam logic [3:0] ST_FA = 4'd7;
	localparam logic [3:0] ST_ACC = 4'd8;

	localparam logic [1:0] PH_PM = 2'd0;
	localparam logic [1:0] PH_HF = 2'd1;
	localparam logic [1:0] PH_HFA = 2'd2;
	localparam logic [1:0] PH_SLOPE = 2'd3;

	logic [31:0] ln_tab [LOG_TABLE_ENTRIES + 1];

	for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_tab
		localparam logic [31:0] ENTRY = ln_entry(gi, LOG_TABLE_ENTRIES);
		assign ln_tab[gi] = ENTRY;
	end

	logic [3:0] state_q;
	logic [1:0] ph_q;
	logic [1:0] cnt_q;
	ehf_item_t item_q;
	logic [OP_W-1:0] op_a_q;
	logic [OP_W-1:0] op_b_q;
	logic [P_W-1:0] p_q;
	logic signed [FA_W-1:0] fa_q;
	logic [5:0] e_q;
	logic [31:0] frac_q;
	logic [IW-1:0] idx_q;
	logic [31:0] rem_q;
	logic [31:0] ip_q;
	logic signed [L_W-1:0] l_q;
	logic signed [TERM_W-1:0] hf_q;
	logic signed [TERM_W-1:0] hfa_q;
	logic signed [TERM_W-1:0] slope_q;
	logic zflag_q;
	logic signed [SUM_W-1:0] sum_e_q;
	logic signed [SUM_W-1:0] sum_c_q;
	logic signed [SUM_W-1:0] sum_s_q;
	logic zero_seen_q;
	logic out_valid_q;
	logic signed [SUM_W-1:0] out_e_q;
	logic signed [SUM_W-1:0] out_c_q;
	logic signed [SUM_W-1:0] out_s_q;
	logic out_z_q;

	// log front half: y = 9x, top bit, fraction below it
	logic [45:0] y;
	logic [5:0] e_c;
	logic [45:0] r_c;
	logic [77:0] sh_c;
	always_comb begin
		y = {1'b0, op_a_q[X_W-1:0], 3'b000} + {4'b0000, op_a_q[X_W-1:0]};
		e_c = '0;
		for (int i = 0; i < 46; i++) begin
			if (y[i]) begin
				e_c = 6'(i);
			end
		end
		r_c = y & ~(46'd1 << e_c);
		sh_c = {r_c, 32'd0} >> e_c;
	end

	logic [32+IW-1:0] pos_c;
	assign pos_c = (32 + IW)'(frac_q) * (32 + IW)'(LOG_TABLE_ENTRIES);

	logic [31:0] tab_lo;
	logic [31:0] tab_hi;
	logic [63:0] dprod;
	assign tab_lo = ln_tab[idx_q];
	assign tab_hi = ln_tab[idx_q + 1'b1];
	assign dprod = 64'(tab_hi - tab_lo) * 64'(rem_q);

	logic signed [6:0] ek;
	logic signed [L_W-1:0] l_c;
	logic [L_W-1:0] l_mag;
	always_comb begin
		ek = $signed({1'b0, e_q}) + $signed({4'b0000, item_q.k}) - 7'sd33;
		l_c = L_W'(ek) * $signed({8'd0, LN2_Q32}) + $signed({8'd0, ip_q});
		l_mag = l_c[L_W-1] ? L_W'(-l_c) : L_W'(l_c);
	end

	// one 32x32 partial product a cycle
	logic [31:0] a_sel;
	logic [31:0] b_sel;
	logic [63:0] pp;
	logic [P_W-1:0] pp_sh;
	always_comb begin
		a_sel = cnt_q[1] ? {16'd0, op_a_q[47:32]} : op_a_q[31:0];
		b_sel = cnt_q[0] ? {16'd0, op_b_q[47:32]} : op_b_q[31:0];
		pp = 64'(a_sel) * 64'(b_sel);
		unique case (cnt_q)
			2'd0: pp_sh = P_W'(pp);
			2'd1, 2'd2: pp_sh = P_W'(pp) << 32;
			default: pp_sh = P_W'(pp) << 64;
		endcase
	end

	// round half up on the magnitude, then cap
	logic [P_W-1:0] rnd;
	logic [P_W-1:0] q_full;
	logic [OP_W-1:0] cap;
	logic [OP_W-1:0] mq;
	logic signed [TERM_W-1:0] mq_pos;
	logic signed [TERM_W-1:0] mq_neg;
	always_comb begin
		if (ph_q == PH_PM) begin
			rnd = p_q + (P_W'(1) << 27);
			q_full = rnd >> 28;
			cap = OP_W'(1) << 40;
		end else begin
			rnd = p_q + (P_W'(1) << 29);
			q_full = rnd >> 30;
			cap = OP_W'(1) << 47;
		end
		mq = (q_full > P_W'(cap)) ? cap : q_full[OP_W-1:0];
		mq_pos = $signed({2'b00, mq});
		mq_neg = -mq_pos;
	end

	logic signed [FA_W-1:0] f_ext;
	logic signed [FA_W-1:0] pm_ext;
	logic [FA_W-1:0] fa_mag;
	logic signed [L_W-1:0] g_c;
	logic slope_neg;
	always_comb begin
		f_ext = FA_W'(item_q.f);
		pm_ext = $signed({2'b00, mq[40:0]});
		fa_mag = fa_q[FA_W-1] ? FA_W'(-fa_q) : FA_W'(fa_q);
		g_c = l_q + (L_W'(1) <<< 32);
		slope_neg = (fa_q[FA_W-1] != item_q.diff[F_W]) != g_c[L_W-1];
	end

	logic signed [ACC_W-1:0] ne_c;
	logic signed [ACC_W-1:0] nc_c;
	logic signed [ACC_W-1:0] ns_c;
	logic out_free;
	always_comb begin
		ne_c = ACC_W'(sum_e_q) + ACC_W'(hf_q);
		nc_c = ACC_W'(sum_c_q) + ACC_W'(hfa_q) - ACC_W'(hf_q);
		ns_c = ACC_W'(sum_s_q) + ACC_W'(slope_q);
		out_free = !out_valid_q || !out_stall;
	end

	assign pop = (state_q == ST_IDLE) && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= PH_PM;
			cnt_q <= '0;
			sum_e_q <= '0;
			sum_c_q <= '0;
			sum_s_q <= '0;
			zero_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rd_valid) begin
						ph_q <= PH_PM;
						cnt_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					cnt_q <= '0;
					unique case (ph_q)
						PH_PM: begin
							if (item_q.f > 0) begin
								ph_q <= PH_HF;
								state_q <= ST_LN1;
							end else begin
								state_q <= ST_FA;
							end
						end
						PH_HF: state_q <= ST_FA;
						PH_HFA: begin
							ph_q <= PH_SLOPE;
							state_q <= ST_MUL;
						end
						default: state_q <= ST_ACC;
					endcase
				end
				ST_LN1: state_q <= ST_LN2;
				ST_LN2: state_q <= ST_LN3;
				ST_LN3: state_q <= ST_LN4;
				ST_LN4: begin
					cnt_q <= '0;
					state_q <= ST_MUL;
				end
				ST_FA: begin
					if (fa_q == '0) begin
						state_q <= ST_ACC;
					end else begin
						ph_q <= PH_HFA;
						state_q <= ST_LN1;
					end
				end
				ST_ACC: begin
					if (!item_q.last) begin
						sum_e_q <= sat_sum(ne_c);
						sum_c_q <= sat_sum(nc_c);
						sum_s_q <= sat_sum(ns_c);
						zero_seen_q <= zero_seen_q | zflag_q;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						sum_e_q <= '0;
						sum_c_q <= '0;
						sum_s_q <= '0;
						zero_seen_q <= 1'b0;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && rd_valid) begin
			item_q <= rd_item;
			op_a_q <= OP_W'(rd_item.mag_alpha);
			op_b_q <= OP_W'(rd_item.mag_diff);
			hf_q <= '0;
		end
		if (state_q == ST_MUL) begin
			p_q <= (cnt_q == 2'd0) ? pp_sh : p_q + pp_sh;
		end
		if (state_q == ST_RND) begin
			unique case (ph_q)
				PH_PM: begin
					fa_q <= item_q.pm_neg ? f_ext - pm_ext : f_ext + pm_ext;
					op_a_q <= OP_W'(item_q.f[F_W-2:0]);
				end
				PH_HF: hf_q <= l_q[L_W-1] ? mq_neg : mq_pos;
				PH_HFA: begin
					hfa_q <= l_q[L_W-1] ? mq_neg : mq_pos;
					op_a_q <= OP_W'(item_q.mag_diff);
					op_b_q <= g_c[L_W-1] ? OP_W'(-g_c) : OP_W'(g_c);
				end
				default: slope_q <= slope_neg ? mq_neg : mq_pos;
			endcase
		end
		if (state_q == ST_LN1) begin
			e_q <= e_c;
			frac_q <= sh_c[31:0];
		end
		if (state_q == ST_LN2) begin
			idx_q <= pos_c[32 +: IW];
			rem_q <= pos_c[31:0];
		end
		if (state_q == ST_LN3) begin
			ip_q <= tab_lo + dprod[63:32];
		end
		if (state_q == ST_LN4) begin
			l_q <= l_c;
			op_b_q <= OP_W'(l_mag);
		end
		if (state_q == ST_FA) begin
			zflag_q <= fa_q == '0;
			op_a_q <= OP_W'(fa_mag[X_W-1:0]);
			if (fa_q == '0) begin
				hfa_q <= '0;
				if (item_q.diff > 0) begin
					slope_q <= -(TERM_W'(1) <<< 47);
				end else if (item_q.diff < 0) begin
					slope_q <= TERM_W'(1) <<< 47;
				end else begin
					slope_q <= '0;
				end
			end
		end
		if (state_q == ST_ACC && item_q.last && out_free) begin
			out_e_q <= sat_sum(ne_c);
			out_c_q <= sat_sum(nc_c);
			out_s_q <= sat_sum(ns_c);
			out_z_q <= zero_seen_q | zflag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign entropy_sum = out_e_q;
	assign entropy_change = out_c_q;
	assign entropy_slope = out_s_q;
	assign zero_hit = out_z_q;

	a_clear_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> sum_e_q == '0 && sum_c_q == '0 && sum_s_q == '0 && !zero_seen_q)
		else $error("sums not cleared when a result was emitted");

	a_zero_fa: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FA && fa_q == '0 |=> state_q == ST_ACC && zflag_q)
		else $error("zero fa did not take the saturated slope path");

	a_mul_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |=> state_q == ST_MUL || state_q == ST_RND)
		else $error("multiply sequence broken");

endmodule

// ===== rtl/entropic_h_function_accumulator_core.sv =====
// Path from request accept to result: front stage, queue, back sequencer.
// The back sequencer takes one request at a time and sets the rate; it takes longest when
//   f > 0 and fa != 0 (two log evaluations and four 32x32 product sequences).
// The front takes a new request while the back works; a 4-entry queue sits between them.
// Reset (arst_n low, asynchronous): sums and zero flag cleared, queue emptied, no result pending.
// The ln table is constant logic, so no fill pass follows reset.
module entropic_h_function_accumulator_core import ehf_pkg::*; #(
	parameter int LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [F_W-1:0] f_value,
	input  logic signed [F_W-1:0] feq_value,
	input  logic signed [F_W-1:0] alpha,
	input  logic [3:0] direction,
	input  logic last,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [SUM_W-1:0] entropy_sum,
	output logic signed [SUM_W-1:0] entropy_change,
	output logic signed [SUM_W-1:0] entropy_slope,
	output logic zero_hit
);

	// front -> queue
	logic push;
	ehf_item_t push_item;
	logic q_full;

	// queue -> back
	logic rd_valid;
	ehf_item_t rd_item;
	logic pop;

	// Front: registers the request, forms feq-f, magnitudes and the weight class.
	ehf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.f_value   (f_value),
		.feq_value (feq_value),
		.alpha     (alpha),
		.direction (direction),
		.last      (last),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	// Short queue decoupling classification from the arithmetic sequencer.
	ehf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.rd_valid  (rd_valid),
		.rd_item   (rd_item)
	);

	// Back: shared 32x32 multiplier, table-interpolated ln, saturating sums,
	// output register so the next request proceeds while a result waits.
	ehf_back #(
		.LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rd_valid       (rd_valid),
		.rd_item        (rd_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.entropy_sum    (entropy_sum),
		.entropy_change (entropy_change),
		.entropy_slope  (entropy_slope),
		.zero_hit       (zero_hit)
	);

endmodule

// ===== sim/entropic_h_function_accumulator_core_tb.sv =====
module entropic_h_function_accumulator_core_tb;
	import ehf_pkg::*;

	// ---------------------------------------------------------------
	// Clock, reset and block ports
	// ---------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] f_value = '0;
	logic signed [31:0] feq_value = '0;
	logic signed [31:0] alpha = '0;
	logic [3:0] direction = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [47:0] entropy_sum;
	logic signed [47:0] entropy_change;
	logic signed [47:0] entropy_slope;
	logic zero_hit;

	always #5 clk = ~clk;

	entropic_h_function_accumulator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.f_value(f_value), .feq_value(feq_value), .alpha(alpha),
		.direction(direction), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.entropy_sum(entropy_sum), .entropy_change(entropy_change),
		.entropy_slope(entropy_slope), .zero_hit(zero_hit)
	);

	localparam int LN_ENTRIES = 256;
	localparam longint ONE_Q32 = 64'sd4294967296;
	localparam longint TERM_CAP = 64'sd140737488355328;
	localparam longint SUM_HI = 64'sd140737488355327;
	localparam longint SUM_LO = -64'sd140737488355328;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [47:0] esum;
		logic [47:0] echg;
		logic [47:0] eslope;
		logic zflag;
	} site_result_t;

	site_result_t site_results[$];

	// running site sums of the model
	longint acc_entropy, acc_change, acc_slope;
	logic acc_zero;
	longint unsigned ln_tab[0:LN_ENTRIES];

	int fails = 0;
	int requests = 0;
	int sites_checked = 0;
	int zero_sites = 0;
	int cycles = 0;

	// typed expectation for directed rows that carry one
	logic use_typed = 1'b0;
	site_result_t typed_res;

	// ---------------------------------------------------------------
	// Fixed point model
	// ---------------------------------------------------------------
	// ln(1 + i/N) in Q.32 from the atanh series
	function automatic longint unsigned ln_seed(int i);
		longint unsigned z, z2, p, acc, n;
		z = (64'(i) << 32) / 64'(2 * LN_ENTRIES + i);
		z2 = (z * z) >> 32;
		p = z;
		acc = 0;
		n = 1;
		while (p != 0) begin
			acc += p / n;
			p = (p * z2) >> 32;
			n += 2;
		end
		return acc * 2;
	endfunction

	// rounded a*b >> s on magnitudes, clipped at cap
	function automatic longint unsigned mul_rnd(longint unsigned a, longint unsigned b,
			int s, longint unsigned cap);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b} + (128'd1 << (s - 1))) >> s;
		if (p[127:64] != 0) return cap;
		return (p[63:0] > cap) ? cap : p[63:0];
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// ln(w*x), Q.32 signed; x is a Q.30 magnitude, w = 9 * 2^(k-3)
	function automatic longint ln_w(longint unsigned x, int k);
		longint unsigned y, r, frac, pos, idx, rem, lo, interp;
		int e;
		y = x * 9;
		e = 0;
		while (e < 63 && (y >> (e + 1)) != 0) e++;
		r = y - (64'd1 << e);
		frac = (e >= 32) ? (r >> (e - 32)) : (r << (32 - e));
		pos = frac * LN_ENTRIES;
		idx = pos >> 32;
		rem = pos & 64'hFFFF_FFFF;
		lo = ln_tab[idx];
		interp = lo + (((ln_tab[idx + 1] - lo) * rem) >> 32);
		return longint'(e + k - 33) * longint'({32'd0, LN2_Q32}) + longint'(interp);
	endfunction

	function automatic longint h_of(longint unsigned x, int k);
		longint l;
		longint unsigned m;
		if (x == 0) return 0;
		l = ln_w(x, k);
		m = mul_rnd(x, mag(l), 30, TERM_CAP);
		return l < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clip_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (s > SUM_HI) return SUM_HI;
		if (s < SUM_LO) return SUM_LO;
		return s;
	endfunction

	// fold one request into the site sums; returns 1 when the site closes
	function automatic bit fold_request(longint fv, longint feqv, longint av,
			int d, bit lst, output site_result_t res);
		longint diff, fa, hf, slope, g;
		longint unsigned pm, m;
		int k;
		bit neg;
		diff = feqv - fv;
		if (d >= DIRECTIONS) d = DIRECTIONS - 1;
		k = (d == 0) ? int'(K_CENTER) : ((d < FIRST_DIAG) ? int'(K_AXIS) : int'(K_DIAG));
		pm = mul_rnd(mag(av), mag(diff), 28, 64'd1 << 40);
		fa = ((av < 0) != (diff < 0)) ? fv - longint'(pm) : fv + longint'(pm);
		hf = (fv > 0) ? h_of(fv, k) : 0;
		acc_entropy = clip_sum(acc_entropy, hf);
		acc_change = clip_sum(acc_change, h_of(mag(fa), k) - hf);
		if (fa == 0) begin
			// saturated slope; direction set by feq - f
			acc_zero = 1'b1;
			slope = (diff > 0) ? -TERM_CAP : ((diff < 0) ? TERM_CAP : 0);
		end else begin
			g = ln_w(mag(fa), k) + ONE_Q32;
			m = mul_rnd(mag(diff), mag(g), 30, TERM_CAP);
			neg = ((fa < 0) != (diff < 0)) != (g < 0);
			slope = neg ? -longint'(m) : longint'(m);
		end
		acc_slope = clip_sum(acc_slope, slope);
		res.esum = acc_entropy[47:0];
		res.echg = acc_change[47:0];
		res.eslope = acc_slope[47:0];
		res.zflag = acc_zero;
		if (!lst) return 0;
		acc_entropy = 0;
		acc_change = 0;
		acc_slope = 0;
		acc_zero = 1'b0;
		return 1;
	endfunction

	// ---------------------------------------------------------------
	// Monitors: requests accepted feed the model, results are checked
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		site_result_t r;
		site_result_t x;
		cycles <= cycles + 1;
		if (arst_n && in_valid && !in_stall) begin
			requests <= requests + 1;
			if (fold_request(longint'(f_value), longint'(feq_value), longint'(alpha),
					int'(direction), last, r))
				site_results.push_back(use_typed ? typed_res : r);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (site_results.size() == 0) begin
				$error("unexpected result: no site pending");
				fails = fails + 1;
			end else begin
				x = site_results.pop_front();
				sites_checked <= sites_checked + 1;
				if (zero_hit) zero_sites <= zero_sites + 1;
				if (entropy_sum !== x.esum) begin
					$error("entropy_sum exp %0d got %0d", $signed(x.esum), entropy_sum);
					fails = fails + 1;
				end
				if (entropy_change !== x.echg) begin
					$error("entropy_change exp %0d got %0d", $signed(x.echg), entropy_change);
					fails = fails + 1;
				end
				if (entropy_slope !== x.eslope) begin
					$error("entropy_slope exp %0d got %0d", $signed(x.eslope), entropy_slope);
					fails = fails + 1;
				end
				if (zero_hit !== x.zflag) begin
					$error("zero_hit exp %0b got %0b", x.zflag, zero_hit);
					fails = fails + 1;
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Idle pattern: mostly short gaps, a few long, and quiet stretches
	// ---------------------------------------------------------------
	bit quiet = 1'b0;

	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= gap_len();
			out_stall <= ($urandom_range(0, 2) == 0) && !quiet;
		end
	end

	// ---------------------------------------------------------------
	// Request driver
	// ---------------------------------------------------------------
	task automatic send(logic signed [31:0] fv, logic signed [31:0] feqv,
			logic signed [31:0] av, logic [3:0] d, logic lst);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		f_value = fv;
		feq_value = feqv;
		alpha = av;
		direction = d;
		last = lst;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// directed rows; typed expectations where they are obvious
	typedef struct {
		logic signed [31:0] fv, feqv, av;
		logic [3:0] d;
		logic lst;
		bit typed;
		logic signed [47:0] es, ec, sl;
		logic zh;
	} row_t;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [31:0] ALPHA_ONE = 32'sh1000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	row_t rows[] = '{
		// all zero: fa is zero with feq == f, slope term zero, flag set
		'{0, 0, 0, 4'd0, 1'b1, 1, 48'sd0, 48'sd0, 48'sd0, 1'b1},
		// fa hits zero with feq > f twice: slope sum pins at the negative rail
		'{-ONE_Q30, 0, ALPHA_ONE, 4'd15, 1'b0, 0, 0, 0, 0, 0},
		'{-ONE_Q30, 0, ALPHA_ONE, 4'd3, 1'b1, 1, 48'sd0, 48'sd0,
			-48'sh8000_0000_0000, 1'b1},
		// fa hits zero with feq < f: positive rail term
		'{ONE_Q30, 0, ALPHA_ONE, 4'd7, 1'b1, 0, 0, 0, 0, 0},
		// one per weight class, ordinary values
		'{32'sd300000000, 32'sd280000000, 32'sh2000_0000, 4'd0, 1'b0, 0, 0, 0, 0, 0},
		'{32'sd70000000, 32'sd72000000, 32'sh2000_0000, 4'd1, 1'b0, 0, 0, 0, 0, 0},
		'{32'sd17000000, 32'sd16000000, 32'sh2000_0000, 4'd14, 1'b1, 0, 0, 0, 0, 0},
		// field extremes
		'{S32_MAX, S32_MIN, S32_MAX, 4'd6, 1'b0, 0, 0, 0, 0, 0},
		'{S32_MIN, S32_MAX, S32_MIN, 4'd15, 1'b0, 0, 0, 0, 0, 0},
		'{S32_MAX, S32_MAX, S32_MIN, 4'd0, 1'b0, 0, 0, 0, 0, 0},
		'{S32_MIN, S32_MIN, S32_MAX, 4'd8, 1'b1, 0, 0, 0, 0, 0},
		// smallest positive f, negative f, alpha zero
		'{1, 2, ALPHA_ONE, 4'd2, 1'b0, 0, 0, 0, 0, 0},
		'{-1, 5, 0, 4'd9, 1'b0, 0, 0, 0, 0, 0},
		'{5, -3, -32'sd1, 4'd5, 1'b1, 0, 0, 0, 0, 0},
		// big terms repeatedly: sums grow large but stay below the rails
		'{S32_MAX, S32_MIN, S32_MAX, 4'd15, 1'b0, 0, 0, 0, 0, 0},
		'{S32_MAX, S32_MIN, S32_MAX, 4'd15, 1'b0, 0, 0, 0, 0, 0},
		'{S32_MAX, S32_MIN, S32_MAX, 4'd15, 1'b0, 0, 0, 0, 0, 0},
		'{S32_MAX, S32_MIN, S32_MAX, 4'd15, 1'b1, 0, 0, 0, 0, 0}
	};

	// random site direction value near equilibrium, Q2.30
	function automatic logic signed [31:0] near(logic signed [31:0] base);
		return base + $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
	endfunction

	initial begin
		int n, i, d, sz;
		logic signed [31:0] fv, feqv, av;
		bit broken;
		for (i = 0; i <= LN_ENTRIES; i++) ln_tab[i] = ln_seed(i);
		acc_entropy = 0;
		acc_change = 0;
		acc_slope = 0;
		acc_zero = 1'b0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		foreach (rows[j]) begin
			use_typed = rows[j].typed;
			typed_res = '{rows[j].es, rows[j].ec, rows[j].sl, rows[j].zh};
			send(rows[j].fv, rows[j].feqv, rows[j].av, rows[j].d, rows[j].lst);
		end
		use_typed = 1'b0;

		// random part: mostly whole sites with plausible values,
		// some noise and sites cut short
		n = 0;
		while (n < 1850) begin
			if ($urandom_range(0, 7) == 0) quiet = !quiet;
			broken = ($urandom_range(0, 9) == 0);
			sz = broken ? $urandom_range(1, 20) : DIRECTIONS;
			for (d = 0; d < sz; d++) begin
				case ($urandom_range(0, 19))
					0, 1: begin
						fv = $urandom;
						feqv = $urandom;
						av = $urandom;
					end
					2: begin
						// fa exactly zero
						feqv = ($urandom_range(0, 3) == 0) ? 0 : near(32'sd0);
						fv = near(32'sd50000000);
						av = ALPHA_ONE;
						if (feqv != 0) begin
							fv = feqv;
						end
						feqv = 0;
						if ($urandom_range(0, 1)) fv = -fv;
					end
					3: begin
						fv = near(0);
						feqv = near(0);
						av = $signed(32'($urandom_range(0, 32'h6000_0000)));
					end
					default: begin
						fv = near((d == 0) ? 32'sd300000000 :
							(d < FIRST_DIAG) ? 32'sd120000000 : 32'sd15000000);
						feqv = near(fv);
						av = 32'sh2000_0000 + $signed(32'($urandom_range(0, 32'h0800_0000)))
							- 32'sh0400_0000;
					end
				endcase
				send(fv, feqv, av,
					($urandom_range(0, 30) == 0) ? 4'd15 : 4'(d % 15),
					broken ? ($urandom_range(0, 3) == 0) : (d == sz - 1));
				n++;
			end
		end
		// close any open site so its sums get checked too
		send(0, 0, 0, 4'd0, 1'b1);
		in_valid = 1'b0;
		quiet = 1'b0;

		while (site_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("sent %0d requests, checked %0d site results (%0d with a zero fa)",
			requests, sites_checked, zero_sites);
		$display("directed extremes, saturation and zero fa cases plus random sites");
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
